### design/qxmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qxmm_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int SPEED_W    = 10;
    localparam int TERM_W     = 13;
    localparam int STEP_W     = 6;
    localparam int MIX_W      = 16;
    localparam int DIFF_W     = 12;

    typedef logic [SPEED_W-1:0] speed_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [MIX_W-1:0] mix_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_NORMAL     = 2'd1,
        MODE_FIX_HEIGHT = 2'd2,
        MODE_FAIL       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_SPEED_LIMIT     = 2'd0,
        REG_YAW_LIMIT       = 2'd1,
        REG_THROTTLE_CUTOFF = 2'd2,
        REG_FAIL_STEP       = 2'd3
    } reg_index_t;

    localparam speed_t            SPEED_LIMIT_RST     = 10'd700;
    localparam speed_t            YAW_LIMIT_RST       = 10'd100;
    localparam speed_t            THROTTLE_CUTOFF_RST = 10'd50;
    localparam logic [STEP_W-1:0] FAIL_STEP_RST       = 6'd2;

    localparam int MOTOR_FL = 0;
    localparam int MOTOR_RL = 1;
    localparam int MOTOR_FR = 2;
    localparam int MOTOR_RR = 3;

    typedef struct packed {
        speed_t              speed_limit;
        speed_t              yaw_limit;
        speed_t              throttle_cutoff;
        logic [STEP_W-1:0]   fail_step;
    } cfg_t;

    typedef struct packed {
        mode_t  mode;
        speed_t throttle;
        term_t  pitch_term;
        term_t  roll_term;
        term_t  yaw_term;
        term_t  height_term;
    } item_t;

    typedef struct packed {
        speed_t [NUM_MOTORS-1:0] speeds;
        logic                    fail_done;
    } result_t;

endpackage

`default_nettype wire

### design/quad_x_motor_mixer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Quad X-frame motor mixer. One control period enters per transfer on the slave
// side and yields exactly one result transfer of four motor speeds and a
// fail-done flag. The path is an input register, one pass of mixing, yaw clamp,
// saturation and cutoff logic, and a result register, so a period passes
// through both registers before its result is valid, and a new period is taken every cycle as
// long as the result side keeps up. The result register also holds the stored
// motor speeds that fail mode ramps down; they reset to zero. Registers
// (speed_limit, yaw_limit, throttle_cutoff, fail_step at index 0..3) should be
// written only while no period is in flight.
module quad_x_motor_mixer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // throttle, pitch_term, roll_term,
                                             // yaw_term, height_term, zero pad
    input  wire logic [1:0]  s_axis_tuser,   // mode

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [47:0] m_axis_tdata,   // front_left_speed, rear_left_speed,
                                             // front_right_speed, rear_right_speed,
                                             // fail_done, zero pad
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [9:0]  wr_data
);

    qxmm_pkg::cfg_t    cfg;
    qxmm_pkg::item_t   item_reg;
    qxmm_pkg::item_t   item_in;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    qxmm_pkg::result_t res;
    qxmm_pkg::result_t res_reg;
    logic              advance;
    logic              in_xfer;

    qxmm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    qxmm_mix_core u_core (
        .item       (item_reg),
        .cfg        (cfg),
        .cur_speeds (res_reg.speeds),
        .result     (res)
    );

    always_comb
    begin
        item_in.mode        = qxmm_pkg::mode_t'(s_axis_tuser);
        item_in.throttle    = s_axis_tdata[9:0];
        item_in.pitch_term  = s_axis_tdata[22:10];
        item_in.roll_term   = s_axis_tdata[35:23];
        item_in.yaw_term    = s_axis_tdata[48:36];
        item_in.height_term = s_axis_tdata[61:49];
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_xfer || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= item_in;
    end

    // result register doubles as the stored motor speeds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= '0;
        else if (advance)
            res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg.fail_done,
                            res_reg.speeds[qxmm_pkg::MOTOR_RR],
                            res_reg.speeds[qxmm_pkg::MOTOR_FR],
                            res_reg.speeds[qxmm_pkg::MOTOR_RL],
                            res_reg.speeds[qxmm_pkg::MOTOR_FL]};

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.fail_done |-> (res_reg.speeds == '0))
        else $error("fail_done with nonzero speed");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(item_reg))
        else $error("pending item dropped");

endmodule

`default_nettype wire

### design/qxmm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module qxmm_cfg_regs (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [1:0]             wr_index,
    input  wire logic [9:0]             wr_data,
    output qxmm_pkg::cfg_t              cfg
);

    qxmm_pkg::cfg_t cfg_reg;
    qxmm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (qxmm_pkg::reg_index_t'(wr_index))
                qxmm_pkg::REG_SPEED_LIMIT:     cfg_next.speed_limit = wr_data;
                qxmm_pkg::REG_YAW_LIMIT:       cfg_next.yaw_limit = wr_data;
                qxmm_pkg::REG_THROTTLE_CUTOFF: cfg_next.throttle_cutoff = wr_data;
                qxmm_pkg::REG_FAIL_STEP:
                    cfg_next.fail_step = wr_data[qxmm_pkg::STEP_W-1:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_limit     <= qxmm_pkg::SPEED_LIMIT_RST;
            cfg_reg.yaw_limit       <= qxmm_pkg::YAW_LIMIT_RST;
            cfg_reg.throttle_cutoff <= qxmm_pkg::THROTTLE_CUTOFF_RST;
            cfg_reg.fail_step       <= qxmm_pkg::FAIL_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/qxmm_mix_core.sv
`timescale 1ns / 1ps
`default_nettype none

module qxmm_mix_core (
    input  wire qxmm_pkg::item_t                             item,
    input  wire qxmm_pkg::cfg_t                              cfg,
    input  wire qxmm_pkg::speed_t [qxmm_pkg::NUM_MOTORS-1:0] cur_speeds,
    output qxmm_pkg::result_t                                result
);

    function automatic qxmm_pkg::mix_t sext_term(input qxmm_pkg::term_t v);
        sext_term = qxmm_pkg::mix_t'(v);
    endfunction

    function automatic qxmm_pkg::mix_t zext_speed(input qxmm_pkg::speed_t v);
        zext_speed = qxmm_pkg::mix_t'({1'b0, v});
    endfunction

    qxmm_pkg::mix_t thr;
    qxmm_pkg::mix_t p;
    qxmm_pkg::mix_t r;
    qxmm_pkg::mix_t y_raw;
    qxmm_pkg::mix_t y;
    qxmm_pkg::mix_t h;
    qxmm_pkg::mix_t y_lim;
    qxmm_pkg::mix_t s_lim;
    qxmm_pkg::mix_t mix [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::diff_t diff [qxmm_pkg::NUM_MOTORS];
    logic fail_all_low;
    logic cut;

    always_comb
    begin
        thr   = zext_speed(item.throttle);
        p     = sext_term(item.pitch_term);
        r     = sext_term(item.roll_term);
        y_raw = sext_term(item.yaw_term);
        y_lim = zext_speed(cfg.yaw_limit);
        s_lim = zext_speed(cfg.speed_limit);
        h     = (item.mode == qxmm_pkg::MODE_FIX_HEIGHT) ? sext_term(item.height_term)
                                                          : '0;

        // symmetric yaw clamp
        if (y_raw > y_lim)
            y = y_lim;
        else if (y_raw < -y_lim)
            y = -y_lim;
        else
            y = y_raw;

        fail_all_low = 1'b1;
        for (int i = 0; i < qxmm_pkg::NUM_MOTORS; i++)
        begin
            diff[i] = qxmm_pkg::diff_t'({1'b0, cur_speeds[i]})
                    - qxmm_pkg::diff_t'({1'b0, cfg.fail_step});
            if (!diff[i][qxmm_pkg::DIFF_W-1] && (diff[i] != '0))
                fail_all_low = 1'b0;
        end

        result.fail_done = 1'b0;
        case (item.mode)
            qxmm_pkg::MODE_IDLE:
            begin
                for (int i = 0; i < qxmm_pkg::NUM_MOTORS; i++)
                    mix[i] = '0;
            end
            qxmm_pkg::MODE_FAIL:
            begin
                for (int i = 0; i < qxmm_pkg::NUM_MOTORS; i++)
                    mix[i] = qxmm_pkg::mix_t'(diff[i]);
                result.fail_done = fail_all_low;
            end
            default:
            begin
                mix[qxmm_pkg::MOTOR_FL] = thr + p - r + y + h;
                mix[qxmm_pkg::MOTOR_RL] = thr - p - r - y + h;
                mix[qxmm_pkg::MOTOR_FR] = thr + p + r - y + h;
                mix[qxmm_pkg::MOTOR_RR] = thr - p + r + y + h;
            end
        endcase

        cut = (item.throttle < cfg.throttle_cutoff);

        // saturate to 0..speed_limit, then throttle cutoff
        for (int i = 0; i < qxmm_pkg::NUM_MOTORS; i++)
        begin
            if (cut || mix[i] < 0)
                result.speeds[i] = '0;
            else if (mix[i] > s_lim)
                result.speeds[i] = cfg.speed_limit;
            else
                result.speeds[i] = mix[i][qxmm_pkg::SPEED_W-1:0];
        end
    end

endmodule

`default_nettype wire

### verif/quad_x_motor_mixer_unit_tb.sv
`timescale 1ns / 1ps

module quad_x_motor_mixer_unit_tb;

    typedef struct packed {
        logic             fail_done;
        qxmm_pkg::speed_t rear_right;
        qxmm_pkg::speed_t front_right;
        qxmm_pkg::speed_t rear_left;
        qxmm_pkg::speed_t front_left;
    } mix_out_t;

    class motor_speed_board;
        int       speed_limit;
        int       yaw_limit;
        int       throttle_cutoff;
        int       fail_step;
        int       motor_speed[qxmm_pkg::NUM_MOTORS];
        mix_out_t expected_speeds[$];
        int       errors;

        function new();
            speed_limit     = qxmm_pkg::SPEED_LIMIT_RST;
            yaw_limit       = qxmm_pkg::YAW_LIMIT_RST;
            throttle_cutoff = qxmm_pkg::THROTTLE_CUTOFF_RST;
            fail_step       = qxmm_pkg::FAIL_STEP_RST;
            foreach (motor_speed[i])
                motor_speed[i] = 0;
            errors = 0;
        endfunction

        function void apply_config(int sl, int yl, int tc, int fs);
            speed_limit     = sl & 10'h3ff;
            yaw_limit       = yl & 10'h3ff;
            throttle_cutoff = tc & 10'h3ff;
            fail_step       = fs & 6'h3f;
        endfunction

        function int clip(int v, int lo, int hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction

        function void note_period(qxmm_pkg::mode_t mode, qxmm_pkg::speed_t thr,
                                  qxmm_pkg::term_t pitch, qxmm_pkg::term_t roll,
                                  qxmm_pkg::term_t yaw, qxmm_pkg::term_t height);
            int       mix[qxmm_pkg::NUM_MOTORS];
            int       t;
            int       p;
            int       r;
            int       yc;
            int       h;
            bit       done;
            mix_out_t e;
            t    = thr;
            p    = pitch;
            r    = roll;
            yc   = clip(int'(yaw), -yaw_limit, yaw_limit);
            h    = (mode == qxmm_pkg::MODE_FIX_HEIGHT) ? int'(height) : 0;
            done = 1'b0;
            case (mode)
                qxmm_pkg::MODE_IDLE:
                    foreach (mix[i])
                        mix[i] = 0;
                qxmm_pkg::MODE_FAIL:
                begin
                    done = 1'b1;
                    foreach (mix[i])
                    begin
                        mix[i] = motor_speed[i] - fail_step;
                        if (mix[i] > 0)
                            done = 1'b0;
                    end
                end
                default:
                begin
                    mix[qxmm_pkg::MOTOR_FL] = t + p - r + yc + h;
                    mix[qxmm_pkg::MOTOR_RL] = t - p - r - yc + h;
                    mix[qxmm_pkg::MOTOR_FR] = t + p + r - yc + h;
                    mix[qxmm_pkg::MOTOR_RR] = t - p + r + yc + h;
                end
            endcase
            foreach (mix[i])
            begin
                mix[i] = clip(mix[i], 0, speed_limit);
                if (t < throttle_cutoff)
                    mix[i] = 0;
                motor_speed[i] = mix[i];
            end
            e.front_left  = qxmm_pkg::speed_t'(mix[qxmm_pkg::MOTOR_FL]);
            e.rear_left   = qxmm_pkg::speed_t'(mix[qxmm_pkg::MOTOR_RL]);
            e.front_right = qxmm_pkg::speed_t'(mix[qxmm_pkg::MOTOR_FR]);
            e.rear_right  = qxmm_pkg::speed_t'(mix[qxmm_pkg::MOTOR_RR]);
            e.fail_done   = done;
            expected_speeds.push_back(e);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                         exp_v, act_v);
            end
        endfunction

        function void check_result(logic [47:0] data);
            mix_out_t e;
            mix_out_t a;
            if (expected_speeds.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            e = expected_speeds.pop_front();
            a = data[40:0];
            compare_field("front_left_speed", int'(e.front_left), int'(a.front_left));
            compare_field("rear_left_speed", int'(e.rear_left), int'(a.rear_left));
            compare_field("front_right_speed", int'(e.front_right), int'(a.front_right));
            compare_field("rear_right_speed", int'(e.rear_right), int'(a.rear_right));
            compare_field("fail_done", int'(e.fail_done), int'(a.fail_done));
            compare_field("pad", 0, int'(data[47:41]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [9:0]  wr_data;

    motor_speed_board board;
    bit               tx_gaps_on;
    bit               rx_stall_on;
    bit               hold_req;
    int               hold_left;

    quad_x_motor_mixer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: check each transfer, then pick next ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (hold_req)
            begin
                hold_left = 200;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_stall_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_period(qxmm_pkg::mode_t mode, int thr, int pitch, int roll,
                               int yaw, int height);
        s_axis_tdata  <= {2'b00, qxmm_pkg::term_t'(height), qxmm_pkg::term_t'(yaw),
                          qxmm_pkg::term_t'(roll), qxmm_pkg::term_t'(pitch),
                          qxmm_pkg::speed_t'(thr)};
        s_axis_tuser  <= mode;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_period(mode, qxmm_pkg::speed_t'(thr), qxmm_pkg::term_t'(pitch),
                          qxmm_pkg::term_t'(roll), qxmm_pkg::term_t'(yaw),
                          qxmm_pkg::term_t'(height));
        if (tx_gaps_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(int sl, int yl, int tc, int fs);
        wr_en    <= 1'b1;
        wr_index <= qxmm_pkg::REG_SPEED_LIMIT;
        wr_data  <= sl[9:0];
        @(posedge clk);
        wr_index <= qxmm_pkg::REG_YAW_LIMIT;
        wr_data  <= yl[9:0];
        @(posedge clk);
        wr_index <= qxmm_pkg::REG_THROTTLE_CUTOFF;
        wr_data  <= tc[9:0];
        @(posedge clk);
        wr_index <= qxmm_pkg::REG_FAIL_STEP;
        wr_data  <= {4'b0000, fs[5:0]};
        @(posedge clk);
        wr_en <= 1'b0;
        board.apply_config(sl, yl, tc, fs);
    endtask

    function automatic int rand_term();
        case ($urandom_range(0, 9))
            0: return -4096;
            1: return 4095;
            2, 3, 4, 5: return $urandom_range(0, 400) - 200;
            default: return $urandom & 13'h1fff;
        endcase
    endfunction

    function automatic int rand_throttle();
        case ($urandom_range(0, 11))
            0: return (board.throttle_cutoff > 0) ? board.throttle_cutoff - 1 : 0;
            1: return board.throttle_cutoff;
            2: return 1023;
            3: return $urandom & 10'h3ff;
            default: return $urandom_range(board.throttle_cutoff > 1000 ?
                                           1000 : board.throttle_cutoff, 1000);
        endcase
    endfunction

    // mostly flights followed by a ramp-down, with some stray periods
    task automatic random_periods(int n);
        int              left;
        int              len;
        qxmm_pkg::mode_t m;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(1, 8);
                if (len > left)
                    len = left;
                repeat (len)
                begin
                    m = ($urandom_range(0, 1) == 0) ? qxmm_pkg::MODE_NORMAL
                                                    : qxmm_pkg::MODE_FIX_HEIGHT;
                    send_period(m, rand_throttle(), rand_term(), rand_term(),
                                rand_term(), rand_term());
                end
                left -= len;
                len = $urandom_range(1, 30);
                if (len > left)
                    len = left;
                repeat (len)
                    send_period(qxmm_pkg::MODE_FAIL, rand_throttle(), rand_term(),
                                rand_term(), rand_term(), rand_term());
                left -= len;
            end
            else
            begin
                send_period(qxmm_pkg::mode_t'($urandom_range(0, 3)), $urandom & 10'h3ff,
                            rand_term(), rand_term(), rand_term(), rand_term());
                left--;
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("quad_x_motor_mixer_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        board         = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = qxmm_pkg::MODE_IDLE;
        m_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_index      = qxmm_pkg::REG_SPEED_LIMIT;
        wr_data       = '0;
        tx_gaps_on    = 1'b1;
        rx_stall_on   = 1'b1;
        hold_req      = 1'b0;
        hold_left     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed periods at reset limits
        send_period(qxmm_pkg::MODE_IDLE, 1023, 4095, -4096, 4095, -4096);
        send_period(qxmm_pkg::MODE_NORMAL, 1000, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 500, 4095, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 500, -4096, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 400, 0, 4095, 4095, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 400, 0, -4096, -4096, 0);
        send_period(qxmm_pkg::MODE_FIX_HEIGHT, 300, 10, -20, 30, 4095);
        send_period(qxmm_pkg::MODE_FIX_HEIGHT, 300, 10, -20, 30, -4096);
        send_period(qxmm_pkg::MODE_FIX_HEIGHT, 300, -5, 7, -150, 100);
        send_period(qxmm_pkg::MODE_NORMAL, 49, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 50, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 1023, 4095, 4095, 4095, 4095);
        send_period(qxmm_pkg::MODE_NORMAL, 300, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_FAIL, 300, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_FAIL, 300, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 60, 3, 0, 0, 0);
        // fail with low throttle
        send_period(qxmm_pkg::MODE_FAIL, 10, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_FAIL, 10, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 100, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_FAIL, 100, 4095, 4095, 4095, 4095);
        drain();

        // fail step of zero
        set_config(1000, 1000, 1, 0);
        send_period(qxmm_pkg::MODE_IDLE, 500, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_FAIL, 500, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_NORMAL, 500, 0, 0, 0, 0);
        send_period(qxmm_pkg::MODE_FAIL, 500, 0, 0, 0, 0);
        random_periods(60);
        drain();

        set_config(1023, 1023, 0, 63);
        random_periods(80);
        drain();

        // long receiver hold so the block backs up into its input
        hold_req = 1'b1;
        set_config(0, 0, 1023, 1);
        random_periods(60);
        drain();

        set_config(1000, 1000, 1000, 1);
        random_periods(70);
        drain();

        repeat (5)
        begin
            set_config($urandom_range(200, 1023), $urandom_range(0, 300),
                       $urandom_range(0, 150), $urandom_range(1, 63));
            random_periods(60);
            drain();
        end

        // closing stretch without idling
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        set_config(700, 100, 50, 40);
        random_periods(70);
        drain();

        if (board.errors == 0 && board.pending() == 0)
            $display("quad_x_motor_mixer_unit_tb: PASS");
        else
            $display("quad_x_motor_mixer_unit_tb: FAIL");
        $finish;
    end

endmodule
